[rtl/lpht_pkg.sv]
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned SLOTS_DEF = 1024;
  localparam int unsigned KEY_CNT_W = $clog2(KEY_W);
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(1024);

  // register index as seen in paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISS     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_RESP
  } state_e;

  typedef struct packed {
    mode_e                   mode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } out_rsp_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } tag_t;

endpackage

[rtl/linear_probe_hash_table.sv]
// Top level: APB size register, probe sequencer and result register.
//
// Key/value table with open addressing. A request carries mode, key and value
// on in_req_i under in_valid_i/in_ready_o; each request yields exactly one
// result (status, slot) on out_rsp_o under out_valid_o/out_ready_i.
// The home slot is key mod table_size, found by a bit-serial remainder unit;
// probing then visits at most the active table size of slots in turn, each
// with a memory read (S_READ) and a compare (S_CHECK); S_RESP posts the
// result. One request is in flight at a time, and the next request is taken
// in the cycle after the result is posted.
// The result sits in an output register; a stalled receiver holds it there,
// and a finished request waits until that register frees up.
// After reset the occupied marks are swept to zero while in_ready_o stays
// low; APB writes are taken throughout. table_size resets to 1024, a value
// of 0 acts as 1 and values above SLOTS act as SLOTS.
module linear_probe_hash_table #(
  parameter int unsigned SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lpht_pkg::in_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lpht_pkg::out_rsp_t              out_rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpht_pkg::PADDR_W-1:0]    paddr,
  input  logic [lpht_pkg::PDATA_W-1:0]    pwdata,
  output logic [lpht_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned IW = $clog2(SLOTS);

  lpht_pkg::state_e state_q, state_d;

  logic [lpht_pkg::SIZE_W-1:0]       tbl_size_q;
  logic [31:0]                       size_ext;
  logic [31:0]                       n_sel;
  logic [NW-1:0]                     active_n;

  lpht_pkg::mode_e                   mode_q, mode_d;
  logic [lpht_pkg::KEY_W-1:0]        key_q, key_d;
  logic signed [lpht_pkg::VAL_W-1:0] value_q, value_d;
  logic [IW-1:0]                     idx_q, idx_d;
  logic [NW-1:0]                     cnt_q, cnt_d;
  lpht_pkg::status_e                 res_status_q, res_status_d;
  logic [lpht_pkg::SLOT_W-1:0]       res_slot_q, res_slot_d;

  logic                              out_valid_q, out_valid_d;
  lpht_pkg::out_rsp_t                out_q, out_d;

  logic                              in_fire;
  logic                              mod_start;
  logic                              mod_done;
  logic [IW-1:0]                     mod_rem;
  logic                              st_ready;
  logic                              st_we;
  lpht_pkg::tag_t                    rd_tag;
  logic                              last_try;
  logic [NW-1:0]                     idx_inc;
  logic [IW-1:0]                     idx_next;
  logic                              cfg_we;

  // APB register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == lpht_pkg::REG_TABLE_SIZE);
  assign prdata = (paddr[2] == lpht_pkg::REG_TABLE_SIZE) ?
                  lpht_pkg::PDATA_W'(tbl_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_size_q <= lpht_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      tbl_size_q <= pwdata[lpht_pkg::SIZE_W-1:0];
    end
  end

  assign size_ext = 32'(tbl_size_q);
  assign n_sel    = (size_ext == 32'd0) ? 32'd1 :
                    (size_ext > 32'(SLOTS)) ? 32'(SLOTS) : size_ext;
  assign active_n = n_sel[NW-1:0];

  lpht_mod #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (in_req_i.key),
    .size_i  (active_n),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  lpht_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ready_o  (st_ready),
    .addr_i   (idx_q),
    .we_i     (st_we),
    .key_i    (key_q),
    .value_i  (value_q),
    .rd_tag_o (rd_tag)
  );

  assign in_ready_o = (state_q == lpht_pkg::S_IDLE) && st_ready;
  assign in_fire    = in_valid_i && in_ready_o;
  assign mod_start  = in_fire;

  assign last_try = (cnt_q + NW'(1)) == active_n;
  assign idx_inc  = NW'(idx_q) + NW'(1);
  assign idx_next = (idx_inc == active_n) ? '0 : idx_inc[IW-1:0];

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    key_d        = key_q;
    value_d      = value_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    st_we        = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lpht_pkg::S_IDLE: begin
        if (in_fire) begin
          mode_d  = in_req_i.mode;
          key_d   = in_req_i.key;
          value_d = in_req_i.value;
          cnt_d   = '0;
          state_d = lpht_pkg::S_HASH;
        end
      end
      lpht_pkg::S_HASH: begin
        if (mod_done) begin
          idx_d   = mod_rem;
          state_d = lpht_pkg::S_READ;
        end
      end
      lpht_pkg::S_READ: begin
        state_d = lpht_pkg::S_CHECK;
      end
      lpht_pkg::S_CHECK: begin
        if (!rd_tag.used) begin
          if (mode_q == lpht_pkg::MODE_INSERT) begin
            st_we        = 1'b1;
            res_status_d = lpht_pkg::ST_INSERTED;
            res_slot_d   = lpht_pkg::SLOT_W'(idx_q);
          end else begin
            res_status_d = lpht_pkg::ST_MISS;
            res_slot_d   = '0;
          end
          state_d = lpht_pkg::S_RESP;
        end else if (mode_q == lpht_pkg::MODE_SEARCH && rd_tag.key == key_q) begin
          res_status_d = lpht_pkg::ST_FOUND;
          res_slot_d   = lpht_pkg::SLOT_W'(idx_q);
          state_d      = lpht_pkg::S_RESP;
        end else if (last_try) begin
          res_status_d = (mode_q == lpht_pkg::MODE_INSERT) ?
                         lpht_pkg::ST_FULL : lpht_pkg::ST_MISS;
          res_slot_d   = '0;
          state_d      = lpht_pkg::S_RESP;
        end else begin
          idx_d   = idx_next;
          cnt_d   = cnt_q + NW'(1);
          state_d = lpht_pkg::S_READ;
        end
      end
      lpht_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{status: res_status_q, slot: res_slot_q};
          state_d     = lpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    value_q      <= value_d;
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_no_accept_during_sweep: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> st_ready
  ) else $error("request accepted during occupied-mark sweep");

  a_miss_full_slot_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == lpht_pkg::ST_FULL ||
                    out_rsp_o.status == lpht_pkg::ST_MISS)
    |-> out_rsp_o.slot == '0
  ) else $error("nonzero slot on full or miss");

  a_write_only_free_insert: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (state_q == lpht_pkg::S_CHECK && mode_q == lpht_pkg::MODE_INSERT &&
               !rd_tag.used)
  ) else $error("slot write outside insert into a free slot");

  a_hash_precedes_probe: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == lpht_pkg::S_HASH && mod_done |=> state_q == lpht_pkg::S_READ
  ) else $error("probe did not start after remainder");

endmodule

[rtl/lpht_mod.sv]
// Bit-serial restoring remainder unit: key modulo the active table size.
module lpht_mod #(
  parameter int unsigned SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  input  logic [$clog2(SLOTS+1)-1:0] size_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   rem_o
);

  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [lpht_pkg::KEY_CNT_W-1:0] LAST_BIT =
    lpht_pkg::KEY_CNT_W'(lpht_pkg::KEY_W - 1);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [lpht_pkg::KEY_CNT_W-1:0]      cnt_q, cnt_d;
  logic [lpht_pkg::KEY_W-1:0]          key_q, key_d;
  logic [NW-1:0]                       rem_q, rem_d;
  logic [NW:0]                         trial;
  logic [NW:0]                         diff;

  assign trial = {rem_q, key_q[lpht_pkg::KEY_W-1]};
  assign diff  = trial - {1'b0, size_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    key_d  = key_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      key_d  = key_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, size_i}) ? diff[NW-1:0] : trial[NW-1:0];
      key_d = {key_q[lpht_pkg::KEY_W-2:0], 1'b0};
      cnt_d = cnt_q + lpht_pkg::KEY_CNT_W'(1);
      if (cnt_q == LAST_BIT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IW-1:0];

endmodule

[rtl/lpht_store.sv]
// Slot memories with registered read and a post-reset sweep of the occupied marks.
module lpht_store #(
  parameter int unsigned SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  output logic                              ready_o,
  input  logic [$clog2(SLOTS)-1:0]          addr_i,
  input  logic                              we_i,
  input  logic [lpht_pkg::KEY_W-1:0]        key_i,
  input  logic signed [lpht_pkg::VAL_W-1:0] value_i,
  output lpht_pkg::tag_t                    rd_tag_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_ADDR = IW'(SLOTS - 1);

  lpht_pkg::tag_t                    tag_mem [SLOTS];
  logic signed [lpht_pkg::VAL_W-1:0] val_mem [SLOTS];

  logic           clr_q, clr_d;
  logic [IW-1:0]  clr_addr_q, clr_addr_d;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  lpht_pkg::tag_t wr_tag;
  lpht_pkg::tag_t rd_q;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + IW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign wr_en   = clr_q | we_i;
  assign wr_addr = clr_q ? clr_addr_q : addr_i;
  assign wr_tag  = clr_q ? lpht_pkg::tag_t'('0) :
                           lpht_pkg::tag_t'{used: 1'b1, key: key_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    rd_q <= tag_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i && !clr_q) begin
      val_mem[addr_i] <= value_i;
    end
  end

  assign ready_o  = !clr_q;
  assign rd_tag_o = rd_q;

endmodule
